// ===== sv/ptvc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptvc_pkg: shared types, codes and arithmetic helpers
// Command and status bundles, sequencer codes, register map and the
// rounding and saturation helpers used by the force controller.
// ----------------------------------------------------------------------------
package ptvc_pkg;

  localparam int unsigned AXIS_COUNT = 3;
  localparam int unsigned QP_COUNT   = 10;

  // input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // axis codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // register map
  localparam logic [2:0] REG_POS_GAINS = 3'd0;
  localparam logic [2:0] REG_VEL_GAINS = 3'd1;
  localparam logic [2:0] REG_INT_GAINS = 3'd2;
  localparam logic [2:0] REG_MASS      = 3'd3;
  localparam logic [2:0] REG_GRAVITY   = 3'd4;

  localparam logic [47:0] POS_GAINS_RST = 48'd10995284052480;
  localparam logic [47:0] VEL_GAINS_RST = 48'd4398113620992;
  localparam logic [47:0] INT_GAINS_RST = 48'd1099528405248;
  localparam logic [15:0] MASS_RST      = 16'd384;
  localparam logic [20:0] GRAVITY_RST   = 21'd642689;

  // valid_flags bits
  localparam int unsigned VF_POS_T = 0;
  localparam int unsigned VF_VEL_T = 1;
  localparam int unsigned VF_ACC_T = 2;
  localparam int unsigned VF_POS_M = 3;
  localparam int unsigned VF_VEL_M = 4;

  // quaternion product slots
  localparam logic [3:0] QP_AA = 4'd0;
  localparam logic [3:0] QP_BB = 4'd1;
  localparam logic [3:0] QP_CC = 4'd2;
  localparam logic [3:0] QP_DD = 4'd3;
  localparam logic [3:0] QP_AB = 4'd4;
  localparam logic [3:0] QP_AC = 4'd5;
  localparam logic [3:0] QP_AD = 4'd6;
  localparam logic [3:0] QP_BC = 4'd7;
  localparam logic [3:0] QP_BD = 4'd8;
  localparam logic [3:0] QP_CD = 4'd9;
  localparam logic [3:0] QP_LAST_STEP = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_QUAT,
    ST_COL,
    ST_EMIT
  } ptvc_state_t;

  typedef enum logic [3:0] {
    AX_INIT,
    AX_VEL,
    AX_ACC1,
    AX_ACC2,
    AX_SP,
    AX_ERR,
    AX_EDT,
    AX_INT,
    AX_KP,
    AX_KV,
    AX_KI,
    AX_FF,
    AX_FORCE
  } axis_uop_t;

  typedef enum logic [1:0] {
    RS_LOAD,
    RS_MUL,
    RS_ACC,
    RS_FIN
  } rot_sub_t;

  typedef struct packed {
    logic       accept;
    logic       axis_en;
    axis_uop_t  axis_uop;
    logic       quat_en;
    logic [3:0] quat_step;
    logic       col_en;
    logic [1:0] col;
    logic [1:0] row;
    rot_sub_t   sub;
    logic       emit;
  } ptvc_cmd_t;

  typedef struct packed {
    logic close_cycle;
    logic out_free;
  } ptvc_stat_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_res_t;

  function automatic logic signed [55:0] ext32(input logic signed [31:0] v);
    return {{24{v[31]}}, v};
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [55:0] rnd_shr(input logic signed [55:0] x,
                                                 input int unsigned s);
    logic signed [55:0] bias;
    bias = 56'sd1 <<< (s - 1);
    return (x + bias) >>> s;
  endfunction

  function automatic sat_res_t sat32(input logic signed [55:0] x);
    sat_res_t r;
    if (x > 56'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (x < -56'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] gain_sel(input logic [47:0] g, input logic [1:0] ax);
    logic [15:0] r;
    case (ax)
      AXIS_X:  r = g[15:0];
      AXIS_Y:  r = g[31:16];
      default: r = g[47:32];
    endcase
    return r;
  endfunction

  // quaternion component: 0 w, 1 x, 2 y, 3 z
  function automatic logic [15:0] q_comp(input logic [63:0] q, input logic [1:0] idx);
    logic [15:0] r;
    unique case (idx)
      2'd0: r = q[15:0];
      2'd1: r = q[31:16];
      2'd2: r = q[47:32];
      2'd3: r = q[63:48];
    endcase
    return r;
  endfunction

  // operand pair for each quaternion product slot
  function automatic logic [3:0] qp_pair(input logic [3:0] slot);
    logic [3:0] r;
    case (slot)
      QP_AA:   r = {2'd0, 2'd0};
      QP_BB:   r = {2'd1, 2'd1};
      QP_CC:   r = {2'd2, 2'd2};
      QP_DD:   r = {2'd3, 2'd3};
      QP_AB:   r = {2'd0, 2'd1};
      QP_AC:   r = {2'd0, 2'd2};
      QP_AD:   r = {2'd0, 2'd3};
      QP_BC:   r = {2'd1, 2'd2};
      QP_BD:   r = {2'd1, 2'd3};
      QP_CD:   r = {2'd2, 2'd3};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ptvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptvc_ctrl: sequencer for the force controller
// Walks the axis update and, for a z sample, the quaternion products and
// the body-frame rotation, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ptvc_ctrl import ptvc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  logic [1:0] in_axis,
  output logic       in_stall,
  output ptvc_cmd_t  cmd,
  input  ptvc_stat_t stat
);

  ptvc_state_t state_r, state_nxt;
  axis_uop_t   uop_r, uop_nxt;
  logic [3:0]  qstep_r, qstep_nxt;
  logic [1:0]  col_r, col_nxt;
  logic [1:0]  row_r, row_nxt;
  rot_sub_t    sub_r, sub_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uop_r   <= AX_INIT;
      qstep_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      sub_r   <= RS_LOAD;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
      qstep_r <= qstep_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    qstep_nxt = qstep_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    sub_nxt   = sub_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_SAMPLE && in_axis != AXIS_NONE) begin
          state_nxt = ST_AXIS;
          uop_nxt   = AX_INIT;
        end
      end
      ST_AXIS: begin
        if (uop_r == AX_FORCE) begin
          qstep_nxt = '0;
          state_nxt = stat.close_cycle ? ST_QUAT : ST_IDLE;
        end else begin
          uop_nxt = axis_uop_t'(4'(uop_r) + 4'd1);
        end
      end
      ST_QUAT: begin
        if (qstep_r == QP_LAST_STEP) begin
          state_nxt = ST_COL;
          col_nxt   = '0;
          row_nxt   = '0;
          sub_nxt   = RS_LOAD;
        end else begin
          qstep_nxt = qstep_r + 4'd1;
        end
      end
      ST_COL: begin
        unique case (sub_r)
          RS_LOAD: sub_nxt = RS_MUL;
          RS_MUL:  sub_nxt = RS_ACC;
          RS_ACC: begin
            if (row_r == 2'd2) begin
              sub_nxt = RS_FIN;
            end else begin
              row_nxt = row_r + 2'd1;
              sub_nxt = RS_LOAD;
            end
          end
          RS_FIN: begin
            row_nxt = '0;
            sub_nxt = RS_LOAD;
            if (col_r == 2'd2) begin
              state_nxt = ST_EMIT;
            end else begin
              col_nxt = col_r + 2'd1;
            end
          end
        endcase
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.axis_en   = (state_r == ST_AXIS);
    cmd.axis_uop  = uop_r;
    cmd.quat_en   = (state_r == ST_QUAT);
    cmd.quat_step = qstep_r;
    cmd.col_en    = (state_r == ST_COL);
    cmd.col       = col_r;
    cmd.row       = row_r;
    cmd.sub       = sub_r;
    cmd.emit      = (state_r == ST_EMIT) && stat.out_free;
  end

endmodule

// ===== sv/ptvc_datapath.sv =====
// ----------------------------------------------------------------------------
// ptvc_datapath: registers and shared multiplier of the force controller
// Holds configuration, per-axis state and the result register; one
// 34x22 signed multiplier is time-shared across all products.
// ----------------------------------------------------------------------------
module ptvc_datapath import ptvc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ptvc_cmd_t          cmd,
  output ptvc_stat_t         stat,
  input  logic               in_cmd,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_pos_target,
  input  logic signed [31:0] in_vel_target,
  input  logic signed [31:0] in_acc_target,
  input  logic signed [31:0] in_pos_measured,
  input  logic signed [31:0] in_vel_measured,
  input  logic [4:0]         in_valid_flags,
  input  logic [15:0]        in_time_step,
  input  logic [63:0]        in_attitude_quat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_force_world_x,
  output logic signed [31:0] out_force_world_y,
  output logic signed [31:0] out_force_world_z,
  output logic signed [31:0] out_force_body_x,
  output logic signed [31:0] out_force_body_y,
  output logic signed [31:0] out_force_body_z,
  output logic               out_saturated
);

  // configuration
  logic [47:0] pos_gains_r, vel_gains_r, int_gains_r;
  logic [15:0] mass_r;
  logic [20:0] gravity_r;

  // latched beat
  logic [1:0]         ax_r;
  logic signed [31:0] pt_r, vt_r, at_r, pm_r, vm_r;
  logic [4:0]         vf_r;
  logic [15:0]        dt_r;
  logic [63:0]        q_r;

  // controller state
  logic signed [31:0] sp_held_r [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] loaded_r;
  logic signed [31:0] integ_r [AXIS_COUNT];
  logic signed [31:0] fw_r [AXIS_COUNT];
  logic               sat_r, sat_nxt;

  // working registers
  logic signed [55:0] prod_r, acc_r;
  logic signed [33:0] tmp_r;
  logic signed [31:0] e_r, ed_r;
  logic signed [31:0] qp_r [QP_COUNT];
  logic signed [19:0] rot_r;
  logic signed [31:0] fb_r [AXIS_COUNT];
  logic               out_valid_r;

  logic signed [33:0] mul_a;
  logic signed [21:0] mul_b;
  logic [3:0]         pair;
  logic signed [15:0] q_opa, q_opb;
  logic signed [55:0] acc1_rnd;
  logic signed [31:0] sp_cur, integ_cur;
  sat_res_t           sp_sat, e_sat, ed_sat, int_sat, fw_sat, fb_sat;
  logic signed [33:0] rsum, rnd14;
  logic signed [33:0] aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;

  assign sp_cur    = sp_held_r[ax_r];
  assign integ_cur = integ_r[ax_r];
  assign pair      = qp_pair(cmd.quat_step);
  assign q_opa     = q_comp(q_r, pair[3:2]);
  assign q_opb     = q_comp(q_r, pair[1:0]);
  assign acc1_rnd  = rnd_shr(prod_r, 16);

  assign stat = '{close_cycle: (ax_r == AXIS_Z), out_free: (!out_valid_r || !out_stall)};

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.axis_en) begin
      unique case (cmd.axis_uop)
        AX_INIT: begin
          mul_a = {{2{vt_r[31]}}, vt_r};
          mul_b = {6'b0, dt_r};
        end
        AX_VEL: begin
          mul_a = {{2{at_r[31]}}, at_r};
          mul_b = {6'b0, dt_r};
        end
        AX_ACC2: begin
          mul_a = tmp_r;
          mul_b = {6'b0, dt_r};
        end
        AX_EDT: begin
          mul_a = {{2{e_r[31]}}, e_r};
          mul_b = {6'b0, dt_r};
        end
        AX_INT: begin
          mul_a = {{2{e_r[31]}}, e_r};
          mul_b = {6'b0, gain_sel(pos_gains_r, ax_r)};
        end
        AX_KP: begin
          mul_a = {{2{ed_r[31]}}, ed_r};
          mul_b = {6'b0, gain_sel(vel_gains_r, ax_r)};
        end
        AX_KV: begin
          mul_a = {{2{integ_cur[31]}}, integ_cur};
          mul_b = {6'b0, gain_sel(int_gains_r, ax_r)};
        end
        AX_KI: begin
          mul_a = {18'b0, mass_r};
          mul_b = {1'b0, gravity_r};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (cmd.quat_en && cmd.quat_step != QP_LAST_STEP) begin
      mul_a = {{18{q_opa[15]}}, q_opa};
      mul_b = {{6{q_opb[15]}}, q_opb};
    end else if (cmd.col_en && cmd.sub == RS_MUL) begin
      mul_a = {{2{fw_r[cmd.row][31]}}, fw_r[cmd.row]};
      mul_b = {{2{rot_r[19]}}, rot_r};
    end
  end

  // rotation matrix entry for row, col from the stored quaternion products
  always_comb begin
    aa = {{2{qp_r[QP_AA][31]}}, qp_r[QP_AA]};
    bb = {{2{qp_r[QP_BB][31]}}, qp_r[QP_BB]};
    cc = {{2{qp_r[QP_CC][31]}}, qp_r[QP_CC]};
    dd = {{2{qp_r[QP_DD][31]}}, qp_r[QP_DD]};
    ab = {{2{qp_r[QP_AB][31]}}, qp_r[QP_AB]};
    ac = {{2{qp_r[QP_AC][31]}}, qp_r[QP_AC]};
    ad = {{2{qp_r[QP_AD][31]}}, qp_r[QP_AD]};
    bc = {{2{qp_r[QP_BC][31]}}, qp_r[QP_BC]};
    bd = {{2{qp_r[QP_BD][31]}}, qp_r[QP_BD]};
    cd = {{2{qp_r[QP_CD][31]}}, qp_r[QP_CD]};
    case ({cmd.row, cmd.col})
      4'b0000: rsum = aa + bb - cc - dd;
      4'b0001: rsum = (bc - ad) <<< 1;
      4'b0010: rsum = (ac + bd) <<< 1;
      4'b0100: rsum = (bc + ad) <<< 1;
      4'b0101: rsum = aa - bb + cc - dd;
      4'b0110: rsum = (cd - ab) <<< 1;
      4'b1000: rsum = (bd - ac) <<< 1;
      4'b1001: rsum = (ab + cd) <<< 1;
      4'b1010: rsum = aa - bb - cc + dd;
      default: rsum = '0;
    endcase
    rnd14 = (rsum + 34'sd8192) >>> 14;
  end

  // saturating sums
  always_comb begin
    sp_sat  = sat32(acc_r + (vf_r[VF_ACC_T] ? rnd_shr(prod_r, 17) : 56'sd0));
    e_sat   = sat32(ext32(sp_cur) - ext32(pm_r));
    ed_sat  = sat32(ext32(vt_r) - ext32(vm_r));
    int_sat = sat32(ext32(integ_cur) + rnd_shr(prod_r, 16));
    fw_sat  = sat32(acc_r);
    fb_sat  = sat32(rnd_shr(acc_r, 14));
  end

  always_comb begin
    sat_nxt = sat_r;
    if (cmd.axis_en) begin
      unique case (cmd.axis_uop)
        AX_SP:    sat_nxt = sat_r | (sp_sat.clip & !vf_r[VF_POS_T]);
        AX_ERR:   sat_nxt = sat_r | (e_sat.clip & vf_r[VF_POS_M])
                          | (ed_sat.clip & vf_r[VF_VEL_T] & vf_r[VF_VEL_M]);
        AX_INT:   sat_nxt = sat_r | int_sat.clip;
        AX_FORCE: sat_nxt = sat_r | fw_sat.clip;
        default:  sat_nxt = sat_r;
      endcase
    end else if (cmd.col_en && cmd.sub == RS_FIN) begin
      sat_nxt = sat_r | fb_sat.clip;
    end else if (cmd.emit) begin
      sat_nxt = 1'b0;
    end
  end

  // configuration, control state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gains_r <= POS_GAINS_RST;
      vel_gains_r <= VEL_GAINS_RST;
      int_gains_r <= INT_GAINS_RST;
      mass_r      <= MASS_RST;
      gravity_r   <= GRAVITY_RST;
      loaded_r    <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        integ_r[i] <= '0;
        fw_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POS_GAINS: pos_gains_r <= cfg_data;
          REG_VEL_GAINS: vel_gains_r <= cfg_data;
          REG_INT_GAINS: int_gains_r <= cfg_data;
          REG_MASS:      mass_r      <= cfg_data[15:0];
          REG_GRAVITY:   gravity_r   <= cfg_data[20:0];
          default: ;
        endcase
      end
      sat_r <= sat_nxt;
      if (cmd.accept && in_cmd == CMD_CLEAR) begin
        for (int i = 0; i < AXIS_COUNT; i++) begin
          integ_r[i] <= '0;
        end
      end
      if (cmd.axis_en) begin
        unique case (cmd.axis_uop)
          AX_INIT:  loaded_r[ax_r] <= 1'b1;
          AX_INT:   integ_r[ax_r]  <= int_sat.val;
          AX_FORCE: fw_r[ax_r]     <= fw_sat.val;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.accept) begin
      ax_r <= in_axis;
      pt_r <= in_pos_target;
      vt_r <= in_vel_target;
      at_r <= in_acc_target;
      pm_r <= in_pos_measured;
      vm_r <= in_vel_measured;
      vf_r <= in_valid_flags;
      dt_r <= in_time_step;
      q_r  <= in_attitude_quat;
    end
    if (cmd.axis_en) begin
      unique case (cmd.axis_uop)
        AX_INIT: begin
          if (!loaded_r[ax_r]) begin
            sp_held_r[ax_r] <= vf_r[VF_POS_M] ? pm_r : 32'sd0;
          end
        end
        AX_VEL:  acc_r <= ext32(sp_cur) + (vf_r[VF_VEL_T] ? rnd_shr(prod_r, 16) : 56'sd0);
        AX_ACC1: tmp_r <= acc1_rnd[33:0];
        AX_SP:   sp_held_r[ax_r] <= vf_r[VF_POS_T] ? pt_r : sp_sat.val;
        AX_ERR: begin
          e_r  <= vf_r[VF_POS_M] ? e_sat.val : 32'sd0;
          ed_r <= (vf_r[VF_VEL_T] && vf_r[VF_VEL_M]) ? ed_sat.val : 32'sd0;
        end
        AX_KP:   acc_r <= rnd_shr(prod_r, 8);
        AX_KV:   acc_r <= acc_r + rnd_shr(prod_r, 8);
        AX_KI:   acc_r <= acc_r + rnd_shr(prod_r, 8);
        AX_FF:   acc_r <= acc_r + (vf_r[VF_ACC_T] ? ext32(at_r) : 56'sd0)
                        - ((ax_r == AXIS_Z) ? rnd_shr(prod_r, 8) : 56'sd0);
        default: ;
      endcase
    end
    if (cmd.quat_en && cmd.quat_step != 4'd0) begin
      qp_r[4'(cmd.quat_step - 4'd1)] <= prod_r[31:0];
    end
    if (cmd.col_en) begin
      unique case (cmd.sub)
        RS_LOAD: begin
          rot_r <= rnd14[19:0];
          if (cmd.row == 2'd0) begin
            acc_r <= '0;
          end
        end
        RS_MUL: ;
        RS_ACC: acc_r <= acc_r + prod_r;
        RS_FIN: fb_r[cmd.col] <= fb_sat.val;
      endcase
    end
    if (cmd.emit) begin
      out_force_world_x <= fw_r[0];
      out_force_world_y <= fw_r[1];
      out_force_world_z <= fw_r[2];
      out_force_body_x  <= fb_r[0];
      out_force_body_y  <= fb_r[1];
      out_force_body_z  <= fb_r[2];
      out_saturated     <= sat_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/pid_thrust_vector_controller.sv =====
// ----------------------------------------------------------------------------
// pid_thrust_vector_controller: three-axis PID force controller
// Per-axis setpoint, error integral and world force, with a body-frame
// rotation of the three forces when the z axis sample closes a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat per axis sample or clear command, taken
//   when in_valid is high and in_stall low. in_stall stays high while a beat
//   is being worked on.
//   Result channel (out_*): one beat per z axis sample, carrying the held
//   world forces, the body-frame forces and the saturation flag.
//   Configuration (cfg_*): write gains, mass and gravity while idle.
// Sequence:
//   A clear command and axis value 3 are taken without leaving idle, the
//   latter dropped; an x or y sample runs the 13 axis steps.
//   A z sample runs to its result beat through 13 axis steps, 11
//   quaternion product steps, 30 rotation steps and one hand-off.
//   All products go through the single shared 34x22 multiplier: each
//   product is registered in prod_r and used by the step after it.
// Reset: clears integrals, held forces, setpoint load marks and the
//   saturation flag, and restores the register defaults.
// Stall: a result waits in the output register; the next item is taken
//   meanwhile, and the following result hand-off waits, holding off input.
// ----------------------------------------------------------------------------
module pid_thrust_vector_controller import ptvc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_pos_target,
  input  logic signed [31:0] in_vel_target,
  input  logic signed [31:0] in_acc_target,
  input  logic signed [31:0] in_pos_measured,
  input  logic signed [31:0] in_vel_measured,
  input  logic [4:0]         in_valid_flags,
  input  logic [15:0]        in_time_step,
  input  logic [63:0]        in_attitude_quat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_force_world_x,
  output logic signed [31:0] out_force_world_y,
  output logic signed [31:0] out_force_world_z,
  output logic signed [31:0] out_force_body_x,
  output logic signed [31:0] out_force_body_y,
  output logic signed [31:0] out_force_body_z,
  output logic               out_saturated
);

  ptvc_cmd_t  cmd;
  ptvc_stat_t stat;

  // sequencer: accepts beats and steps the datapath
  ptvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_axis  (in_axis),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: state, shared multiplier and result register
  ptvc_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_axis           (in_axis),
    .in_pos_target     (in_pos_target),
    .in_vel_target     (in_vel_target),
    .in_acc_target     (in_acc_target),
    .in_pos_measured   (in_pos_measured),
    .in_vel_measured   (in_vel_measured),
    .in_valid_flags    (in_valid_flags),
    .in_time_step      (in_time_step),
    .in_attitude_quat  (in_attitude_quat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_force_world_x (out_force_world_x),
    .out_force_world_y (out_force_world_y),
    .out_force_world_z (out_force_world_z),
    .out_force_body_x  (out_force_body_x),
    .out_force_body_y  (out_force_body_y),
    .out_force_body_z  (out_force_body_z),
    .out_saturated     (out_saturated)
  );

endmodule

// ===== sim/tb_pid_thrust_vector_controller.sv =====
// ----------------------------------------------------------------------------
// tb_pid_thrust_vector_controller: self-checking regression for the controller
// Drives axis samples and clear commands with random gaps, predicts each
// result beat in a local model of the controller and compares every field.
// The receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_pid_thrust_vector_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import ptvc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 200;

  // one expected result beat
  typedef struct {
    logic signed [31:0] fw[3];
    logic signed [31:0] fb[3];
    logic               sat;
  } force_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = CMD_SAMPLE;
  logic [1:0] in_axis = AXIS_X;
  logic signed [31:0] in_pos_target = '0, in_vel_target = '0, in_acc_target = '0;
  logic signed [31:0] in_pos_measured = '0, in_vel_measured = '0;
  logic [4:0] in_valid_flags = '0;
  logic [15:0] in_time_step = '0;
  logic [63:0] in_attitude_quat = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_POS_GAINS;
  logic [47:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_force_world_x, out_force_world_y, out_force_world_z;
  logic signed [31:0] out_force_body_x, out_force_body_y, out_force_body_z;
  logic out_saturated;

  pid_thrust_vector_controller DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [47:0] kp_reg, kv_reg, ki_reg;
  logic [15:0] mass_reg;
  logic [20:0] grav_reg;
  logic signed [31:0] sp_held[3], err_int[3], force_held[3];
  logic sp_loaded[3];
  logic sat_flag;

  force_beat_t force_queue[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit hold_off = 1'b0;

  // floor shift and round-half-up shift, on wide signed values
  function automatic longint fshr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint rshr(longint x, int s);
    return fshr(x + (longint'(1) <<< (s - 1)), s);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  task automatic reset_model();
    kp_reg = POS_GAINS_RST;
    kv_reg = VEL_GAINS_RST;
    ki_reg = INT_GAINS_RST;
    mass_reg = MASS_RST;
    grav_reg = GRAVITY_RST;
    for (int i = 0; i < 3; i++) begin
      sp_held[i] = '0;
      sp_loaded[i] = 1'b0;
      err_int[i] = '0;
      force_held[i] = '0;
    end
    sat_flag = 1'b0;
  endtask

  // work out the controller's response to one accepted beat
  task automatic predict_force(logic c, logic [1:0] ax, logic signed [31:0] pt,
                               logic signed [31:0] vt, logic signed [31:0] at,
                               logic signed [31:0] pm, logic signed [31:0] vm,
                               logic [4:0] vf, logic [15:0] dts, logic [63:0] q);
    longint sp, e, ed, acc, f, dt, s;
    longint qa, qb, qc, qd;
    longint r[3][3];
    force_beat_t beat;
    dt = dts;
    if (c == CMD_CLEAR) begin
      for (int i = 0; i < 3; i++) err_int[i] = '0;
      return;
    end
    if (ax == AXIS_NONE) return;
    if (!sp_loaded[ax]) begin
      sp_held[ax] = vf[VF_POS_M] ? pm : 32'sd0;
      sp_loaded[ax] = 1'b1;
    end
    if (vf[VF_POS_T]) sp = pt;
    else begin
      sp = sp_held[ax];
      if (vf[VF_VEL_T]) sp += rshr(longint'(vt) * dt, 16);
      if (vf[VF_ACC_T]) sp += rshr(rshr(longint'(at) * dt, 16) * dt, 17);
    end
    sp_held[ax] = clip32(sp);
    e = vf[VF_POS_M] ? longint'(clip32(longint'(sp_held[ax]) - longint'(pm))) : 0;
    ed = (vf[VF_VEL_T] && vf[VF_VEL_M]) ?
         longint'(clip32(longint'(vt) - longint'(vm))) : 0;
    acc = vf[VF_ACC_T] ? longint'(at) : 0;
    err_int[ax] = clip32(longint'(err_int[ax]) + rshr(e * dt, 16));
    f = rshr(longint'(kp_reg[16*ax +: 16]) * e, 8)
      + rshr(longint'(kv_reg[16*ax +: 16]) * ed, 8)
      + rshr(longint'(ki_reg[16*ax +: 16]) * longint'(err_int[ax]), 8) + acc;
    if (ax == AXIS_Z) f -= rshr(longint'(mass_reg) * longint'(grav_reg), 8);
    force_held[ax] = clip32(f);
    if (ax != AXIS_Z) return;
    qa = $signed(q[15:0]); qb = $signed(q[31:16]);
    qc = $signed(q[47:32]); qd = $signed(q[63:48]);
    r[0][0] = qa*qa + qb*qb - qc*qc - qd*qd;
    r[0][1] = 2 * (qb*qc - qa*qd);
    r[0][2] = 2 * (qa*qc + qb*qd);
    r[1][0] = 2 * (qb*qc + qa*qd);
    r[1][1] = qa*qa - qb*qb + qc*qc - qd*qd;
    r[1][2] = 2 * (qc*qd - qa*qb);
    r[2][0] = 2 * (qb*qd - qa*qc);
    r[2][1] = 2 * (qa*qb + qc*qd);
    r[2][2] = qa*qa - qb*qb - qc*qc + qd*qd;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i][j] = rshr(r[i][j], 14);
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += r[i][j] * longint'(force_held[i]);
      beat.fb[j] = clip32(rshr(s, 14));
    end
    for (int i = 0; i < 3; i++) beat.fw[i] = force_held[i];
    beat.sat = sat_flag;
    sat_flag = 1'b0;
    force_queue.push_back(beat);
  endtask

  // offer one beat after a random gap, hold it until taken; drop valid only
  // when a gap follows, so back-to-back beats keep it high
  task automatic send_sample(logic c, logic [1:0] ax, logic signed [31:0] pt,
                             logic signed [31:0] vt, logic signed [31:0] at,
                             logic signed [31:0] pm, logic signed [31:0] vm,
                             logic [4:0] vf, logic [15:0] dts, logic [63:0] q,
                             bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c; in_axis <= ax;
    in_pos_target <= pt; in_vel_target <= vt; in_acc_target <= at;
    in_pos_measured <= pm; in_vel_measured <= vm;
    in_valid_flags <= vf; in_time_step <= dts; in_attitude_quat <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_force(c, ax, pt, vt, at, pm, vm, vf, dts, q);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_quat();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return {16'($urandom_range(0, 8192) - 4096), 16'($urandom_range(0, 8192) - 4096),
            16'($urandom_range(0, 8192) - 4096), 16'($urandom_range(12000, 16384))};
  endfunction

  task automatic send_random(logic [1:0] ax);
    logic c;
    c = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_SAMPLE;
    send_sample(c, ax, rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
                5'($urandom), 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1000)),
                rand_quat());
  endtask

  // write one register; only called while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POS_GAINS: kp_reg = val;
      REG_VEL_GAINS: kv_reg = val;
      REG_INT_GAINS: ki_reg = val;
      REG_MASS: mass_reg = val[15:0];
      REG_GRAVITY: grav_reg = val[20:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // release the input, wait for every expected beat, then let any tail finish
  task automatic drain();
    in_valid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] unit_q;
    unit_q = 64'h0000_0000_0000_4000;
    // first sample of each axis; x has an invalid measured position: setpoint from zero
    send_sample(CMD_SAMPLE, AXIS_X, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 5'b00110,
                16'hFFFF, unit_q);
    send_sample(CMD_SAMPLE, AXIS_Y, 32'sd0, 32'sd0, 32'sd0, 32'sd131072, 32'sd0, 5'b11000,
                16'd655, unit_q);
    send_sample(CMD_SAMPLE, AXIS_Z, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh7FFF_FFFF, 5'b11111, 16'hFFFF, unit_q);
    // extremes everywhere, ignored axis code and clear command
    send_sample(CMD_SAMPLE, AXIS_NONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'b11111, 16'hFFFF, '1);
    send_sample(CMD_SAMPLE, AXIS_X, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 5'b11111, 16'hFFFF, '1);
    send_sample(CMD_CLEAR, AXIS_Z, '0, '0, '0, '0, '0, 5'b11111, 16'hFFFF, '1);
    send_sample(CMD_SAMPLE, AXIS_Z, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0, 5'b00110,
                16'hFFFF, 64'h8000_8000_8000_8000);
    send_sample(CMD_SAMPLE, AXIS_Y, '0, '0, '0, '0, '0, 5'b00000, 16'd0, '0);
    send_sample(CMD_SAMPLE, AXIS_Z, 32'sd1, '0, '0, 32'sh7FFF_FFFF, '0, 5'b01001, 16'd1,
                64'h7FFF_7FFF_7FFF_7FFF);
    send_sample(CMD_SAMPLE, AXIS_Z, '0, '0, '0, '0, '0, 5'b00000, 16'd0,
                64'h4000_0000_0000_0000);
    drain();
  endtask

  // cycles of x, y, z, or now and then one beat on a random axis, with random content, under given settings
  task automatic test_random_cycles(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_random(2'($urandom));
      else begin
        send_random(AXIS_X);
        send_random(AXIS_Y);
        send_random(AXIS_Z);
      end
    end
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_POS_GAINS, '1);
    write_reg(REG_VEL_GAINS, '1);
    write_reg(REG_INT_GAINS, '1);
    write_reg(REG_MASS, 48'hFFFF);
    write_reg(REG_GRAVITY, 48'h1F_FFFF);
    test_random_cycles(50);
    write_reg(REG_POS_GAINS, '0);
    write_reg(REG_VEL_GAINS, '0);
    write_reg(REG_INT_GAINS, '0);
    write_reg(REG_MASS, '0);
    write_reg(REG_GRAVITY, '0);
    test_random_cycles(40);
    write_reg(REG_POS_GAINS, {$urandom, $urandom});
    write_reg(REG_VEL_GAINS, {$urandom, $urandom});
    write_reg(REG_INT_GAINS, {$urandom, $urandom});
    write_reg(REG_MASS, 48'($urandom));
    write_reg(REG_GRAVITY, 48'($urandom));
    test_random_cycles(40);
  endtask

  // receiver holds off a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        send_sample(CMD_SAMPLE, AXIS_Z, rand_val(), rand_val(), rand_val(), rand_val(),
                    rand_val(), 5'($urandom), 16'($urandom_range(0, 500)), rand_quat(),
                    1'b0);
      end
    join
    drain();
  endtask

  // receiver stall: per-beat random hold, with runs of none
  initial begin
    int unsigned wait_n;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (out_stall) out_stall <= 1'b0;
      else if ($urandom_range(0, 2) != 0) begin
        wait_n = $urandom_range(0, 12);
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n - 1) @(posedge clk);
        end
      end
    end
  end

  // result checker: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    force_beat_t exp_b;
    logic signed [31:0] got[6];
    if (rst_n && out_valid && !out_stall) begin
      if (force_queue.size() == 0) begin
        $error("result beat with no expectation");
        error_count++;
      end else begin
        exp_b = force_queue.pop_front();
        got = '{out_force_world_x, out_force_world_y, out_force_world_z,
                out_force_body_x, out_force_body_y, out_force_body_z};
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== (i < 3 ? exp_b.fw[i] : exp_b.fb[i - 3])) begin
            $error("%s: expected %0d, got %0d",
                   i < 3 ? $sformatf("force_world[%0d]", i) : $sformatf("force_body[%0d]", i - 3),
                   i < 3 ? exp_b.fw[i] : exp_b.fb[i - 3], got[i]);
            error_count++;
          end
        end
        if (out_saturated !== exp_b.sat) begin
          $error("saturated: expected %0b, got %0b", exp_b.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("pid_thrust_vector_controller regression: fail");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_settings();
    test_random_cycles(165);
    if (error_count == 0 && force_queue.size() == 0)
      $display("pid_thrust_vector_controller regression: pass");
    else
      $display("pid_thrust_vector_controller regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ptvc_pkg.sv
sv/ptvc_ctrl.sv
sv/ptvc_datapath.sv
sv/pid_thrust_vector_controller.sv
sim/tb_pid_thrust_vector_controller.sv
